// ===== rtl/core/zbuffer_triangle_rasterizer_assert.svh =====
// Assertion macros for the z-buffer triangle rasterizer.
// Used by zbuffer_triangle_rasterizer.sv; no other dependencies.
`ifndef ZBUFFER_TRIANGLE_RASTERIZER_ASSERT_SVH
`define ZBUFFER_TRIANGLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication.
`define ZBR_ASSERT_IMPLY(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("zbr assertion failed (same cycle)");

// Next-cycle implication.
`define ZBR_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("zbr assertion failed (next cycle)");

`endif

// ===== rtl/core/zbr_pkg.sv =====
// Shared types and constants of the z-buffer triangle rasterizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zbr_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic REG_VIEWPORT_WIDTH  = 1'b0;
   localparam logic REG_VIEWPORT_HEIGHT = 1'b1;

   localparam logic        [8:0]  VIEWPORT_RESET = 9'd256;
   localparam logic signed [15:0] DEPTH_RESET    = 16'sh8000;

   // Numerator width of the interpolation divider.
   localparam int DIV_W = 34;

   typedef struct packed {
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic signed [15:0] z;
   } vertex_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_RDMEM,
      S_RDDATA,
      S_SORT,
      S_ROW,
      S_MUL,
      S_ADD,
      S_DIV,
      S_QUOT,
      S_SWAP,
      S_PLOTB,
      S_SPAN,
      S_SPNX,
      S_PLOT,
      S_PCMP,
      S_RESP
   } state_type;

   // Which interpolated value the divider produces.
   typedef enum logic [2:0] {
      OP_AX,
      OP_AZ,
      OP_BX,
      OP_BZ,
      OP_SZ
   } op_type;

endpackage

`default_nettype wire

// ===== rtl/core/zbuffer_triangle_rasterizer.sv =====
// Z-buffer triangle rasterizer: sequencer, shared divider and pixel stores.
// Depends on zbr_pkg and zbuffer_triangle_rasterizer_assert.svh.
//
//  channel   direction  transfer when               carries
//  req_*     in         req_valid & req_ready        draw or read command
//  rsp_*     out        rsp_valid & rsp_ready        draw done / read data
//  APB       in/out     psel & penable & pwrite      viewport registers
//
// After reset a clearing pass writes every store entry, MAX_WIDTH*MAX_HEIGHT
// entries (65536 at default size); no command is taken until it ends.
// A draw works row by row and pixel by pixel along each span; every
// interpolated value costs one pass through the shared bit-serial divider,
// every plot inside the viewport a read of the depth store and, when the new
// depth is greater, a write of both stores.
// A stalled result waits in the output register while the next command is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "zbuffer_triangle_rasterizer_assert.svh"

module zbuffer_triangle_rasterizer #(
   parameter int MAX_WIDTH  = zbr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = zbr_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic signed [11:0] req_x0,
   input  wire logic signed [11:0] req_y0,
   input  wire logic signed [15:0] req_z0,
   input  wire logic signed [11:0] req_x1,
   input  wire logic signed [11:0] req_y1,
   input  wire logic signed [15:0] req_z1,
   input  wire logic signed [11:0] req_x2,
   input  wire logic signed [11:0] req_y2,
   input  wire logic signed [15:0] req_z2,
   input  wire logic        [23:0] req_fill_color,
   input  wire logic        [15:0] req_read_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_response_kind,
   output logic             [23:0] rsp_pixel_color,
   output logic signed      [15:0] rsp_pixel_depth,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic        [2:0]  paddr,
   input  wire logic        [31:0] pwdata,
   output logic             [31:0] prdata,
   output logic                    pready
);

   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW         = $clog2(STORE_SIZE);
   localparam int DW         = zbr_pkg::DIV_W;
   localparam logic [AW-1:0] CLR_LAST = AW'(STORE_SIZE - 1);
   localparam logic [12:0]   MAXW13   = 13'(MAX_WIDTH);
   localparam logic [12:0]   MAXH13   = 13'(MAX_HEIGHT);
   localparam logic [24:0]   SIZE25   = 25'(STORE_SIZE);
   localparam logic [5:0]    DIV_LAST = 6'(DW - 1);

   // ---------------------------------------------------------------- registers
   zbr_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   zbr_pkg::op_type    op_ff, op_in;
   zbr_pkg::vertex_type v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic               cmd_ff, cmd_in;
   logic [23:0]        color_ff, color_in;
   logic [15:0]        ridx_ff, ridx_in;
   logic [12:0]        dy_ff, dy_in;
   logic signed [11:0] ax_ff, ax_in, bx_ff, bx_in;
   logic signed [15:0] az_ff, az_in, bz_ff, bz_in;
   logic signed [12:0] x_ff, x_in;
   logic signed [30:0] prod1_ff, prod1_in;
   logic signed [31:0] prod2_ff, prod2_in;
   logic [12:0]        den_ff, den_in;
   logic               neg_ff, neg_in;
   logic [DW-1:0]      quo_ff, quo_in;
   logic [12:0]        rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [12:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] pz_ff, pz_in;
   logic [AW-1:0]      paddr_ff, paddr_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [8:0]         vw_ff, vw_in, vh_ff, vh_in;
   logic [23:0]        res_color_ff, res_color_in;
   logic signed [15:0] res_depth_ff, res_depth_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [23:0]        rsp_color_ff, rsp_color_in;
   logic signed [15:0] rsp_depth_ff, rsp_depth_in;

   // ------------------------------------------------------------------ stores
   logic signed [15:0] depth_mem [STORE_SIZE];
   logic [23:0]        color_mem [STORE_SIZE];
   logic signed [15:0] rd_depth_ff;
   logic [23:0]        rd_color_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic signed [15:0] mem_wdepth;
   logic [23:0]        mem_wcolor;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         depth_mem[mem_waddr] <= mem_wdepth;
         color_mem[mem_waddr] <= mem_wcolor;
      end
      rd_depth_ff <= depth_mem[mem_raddr];
      rd_color_ff <= color_mem[mem_raddr];
   end

   // ------------------------------------------------------- derived geometry
   logic [12:0]        total, first, span;
   logic               second;
   logic signed [13:0] row14;
   logic signed [12:0] row;
   logic [12:0]        w_eff, h_eff;
   logic               plot_in_range;
   logic [24:0]        plot_lin, rd_lin;
   logic               rd_in_range;

   always_comb begin
      total  = 13'(13'(v2_ff.y) - 13'(v0_ff.y));
      first  = 13'(13'(v1_ff.y) - 13'(v0_ff.y));
      span   = 13'(13'(v2_ff.y) - 13'(v1_ff.y));
      second = (dy_ff > first) || (first == 13'd0);
      row14  = 14'(v0_ff.y) + $signed({1'b0, dy_ff});
      row    = row14[12:0];
      w_eff  = (13'(vw_ff) > MAXW13) ? MAXW13 : 13'(vw_ff);
      h_eff  = (13'(vh_ff) > MAXH13) ? MAXH13 : 13'(vh_ff);
      plot_in_range = !px_ff[12] && (px_ff[11:0] < w_eff)
                      && !py_ff[12] && (py_ff[11:0] < h_eff);
      plot_lin = 25'(px_ff[11:0]) * 25'(MAX_HEIGHT) + 25'(py_ff[11:0]);
      rd_lin   = 25'(ridx_ff);
      rd_in_range = rd_lin < SIZE25;
   end

   // -------------------------------------------------------- divider operands
   logic signed [16:0] op_base;
   logic signed [17:0] op_delta;
   logic [12:0]        op_num, op_den;
   logic signed [30:0] mul1;
   logic signed [31:0] mul2;

   always_comb begin
      unique case (op_ff)
         zbr_pkg::OP_AX: begin
            op_base  = 17'(v0_ff.x);
            op_delta = 18'(v2_ff.x) - 18'(v0_ff.x);
            op_num   = dy_ff;
            op_den   = total;
         end
         zbr_pkg::OP_AZ: begin
            op_base  = 17'(v0_ff.z);
            op_delta = 18'(v2_ff.z) - 18'(v0_ff.z);
            op_num   = dy_ff;
            op_den   = total;
         end
         zbr_pkg::OP_BX: begin
            if (!second) begin
               op_base  = 17'(v0_ff.x);
               op_delta = 18'(v1_ff.x) - 18'(v0_ff.x);
               op_num   = dy_ff;
               op_den   = first;
            end else begin
               op_base  = 17'(v1_ff.x);
               op_delta = 18'(v2_ff.x) - 18'(v1_ff.x);
               op_num   = dy_ff - first;
               op_den   = span;
            end
         end
         zbr_pkg::OP_BZ: begin
            if (!second) begin
               op_base  = 17'(v0_ff.z);
               op_delta = 18'(v1_ff.z) - 18'(v0_ff.z);
               op_num   = dy_ff;
               op_den   = first;
            end else begin
               op_base  = 17'(v1_ff.z);
               op_delta = 18'(v2_ff.z) - 18'(v1_ff.z);
               op_num   = dy_ff - first;
               op_den   = span;
            end
         end
         default: begin
            op_base  = 17'(az_ff);
            op_delta = 18'(bz_ff) - 18'(az_ff);
            op_num   = 13'(x_ff - 13'(ax_ff));
            op_den   = 13'(13'(bx_ff) - 13'(ax_ff));
         end
      endcase
      mul1 = op_base * $signed({1'b0, op_den});
      mul2 = op_delta * $signed({1'b0, op_num});
   end

   // ------------------------------------------------------- divider datapath
   logic signed [DW-1:0] numer;
   logic [DW-1:0]        numer_mag;
   logic [13:0]          div_t;
   logic                 div_ge;
   logic [13:0]          div_sub;
   logic [DW-1:0]        quot;
   logic signed [15:0]   q16;

   always_comb begin
      numer     = DW'(prod1_ff) + DW'(prod2_ff);
      numer_mag = numer[DW-1] ? DW'(-numer) : DW'(numer);
      div_t     = {rem_ff, quo_ff[DW-1]};
      div_ge    = div_t >= {1'b0, den_ff};
      div_sub   = div_t - {1'b0, den_ff};
      quot      = neg_ff ? DW'(-quo_ff) : quo_ff;
      q16       = quot[15:0];
   end

   // --------------------------------------------------------- vertex sorting
   zbr_pkg::vertex_type s0, s1, s2, st;
   logic                degenerate;

   always_comb begin
      s0 = v0_ff;
      s1 = v1_ff;
      s2 = v2_ff;
      st = s0;
      if (s0.y > s1.y) begin
         st = s0; s0 = s1; s1 = st;
      end
      if (s0.y > s2.y) begin
         st = s0; s0 = s2; s2 = st;
      end
      if (s1.y > s2.y) begin
         st = s1; s1 = s2; s2 = st;
      end
      degenerate = ((v0_ff.y == v1_ff.y) && (v0_ff.y == v2_ff.y))
                   || ((v0_ff.x == v1_ff.x) && (v0_ff.x == v2_ff.x));
   end

   // ------------------------------------------------------------- sequencer
   logic csr_write;
   logic out_free;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      op_in        = op_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      cmd_in       = cmd_ff;
      color_in     = color_ff;
      ridx_in      = ridx_ff;
      dy_in        = dy_ff;
      ax_in        = ax_ff;
      bx_in        = bx_ff;
      az_in        = az_ff;
      bz_in        = bz_ff;
      x_in         = x_ff;
      prod1_in     = prod1_ff;
      prod2_in     = prod2_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      paddr_in     = paddr_ff;
      clr_in       = clr_ff;
      res_color_in = res_color_ff;
      res_depth_in = res_depth_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_color_in = rsp_color_ff;
      rsp_depth_in = rsp_depth_ff;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = paddr_ff;
      mem_wdepth   = pz_ff;
      mem_wcolor   = color_ff;
      mem_raddr    = plot_lin[AW-1:0];

      unique case (state_ff)
         zbr_pkg::S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_ff;
            mem_wdepth = zbr_pkg::DEPTH_RESET;
            mem_wcolor = 24'd0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = zbr_pkg::S_IDLE;
            end
         end
         zbr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_command;
               v0_in    = '{x: req_x0, y: req_y0, z: req_z0};
               v1_in    = '{x: req_x1, y: req_y1, z: req_z1};
               v2_in    = '{x: req_x2, y: req_y2, z: req_z2};
               color_in = req_fill_color;
               ridx_in  = req_read_index;
               state_in = (req_command == zbr_pkg::CMD_READ) ? zbr_pkg::S_RDMEM
                                                             : zbr_pkg::S_SORT;
            end
         end
         zbr_pkg::S_RDMEM: begin
            mem_raddr = rd_lin[AW-1:0];
            state_in  = zbr_pkg::S_RDDATA;
         end
         zbr_pkg::S_RDDATA: begin
            res_color_in = rd_in_range ? rd_color_ff : 24'd0;
            res_depth_in = rd_in_range ? rd_depth_ff : 16'sd0;
            state_in     = zbr_pkg::S_RESP;
         end
         zbr_pkg::S_SORT: begin
            if (degenerate) begin
               state_in = zbr_pkg::S_RESP;
            end else begin
               v0_in    = s0;
               v1_in    = s1;
               v2_in    = s2;
               px_in    = 13'(s2.x);
               py_in    = 13'(s2.y);
               pz_in    = s2.z;
               dy_in    = 13'd0;
               ret_in   = zbr_pkg::S_ROW;
               state_in = zbr_pkg::S_PLOT;
            end
         end
         zbr_pkg::S_ROW: begin
            if (dy_ff == total) begin
               state_in = zbr_pkg::S_RESP;
            end else begin
               op_in    = zbr_pkg::OP_AX;
               state_in = zbr_pkg::S_MUL;
            end
         end
         zbr_pkg::S_MUL: begin
            prod1_in = mul1;
            prod2_in = mul2;
            den_in   = op_den;
            state_in = zbr_pkg::S_ADD;
         end
         zbr_pkg::S_ADD: begin
            neg_in   = numer[DW-1];
            quo_in   = numer_mag;
            rem_in   = 13'd0;
            cnt_in   = 6'd0;
            state_in = zbr_pkg::S_DIV;
         end
         zbr_pkg::S_DIV: begin
            // one quotient bit per cycle, restoring
            rem_in = div_ge ? div_sub[12:0] : div_t[12:0];
            quo_in = {quo_ff[DW-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = zbr_pkg::S_QUOT;
            end
         end
         zbr_pkg::S_QUOT: begin
            unique case (op_ff)
               zbr_pkg::OP_AX: begin
                  ax_in    = q16[11:0];
                  op_in    = zbr_pkg::OP_AZ;
                  state_in = zbr_pkg::S_MUL;
               end
               zbr_pkg::OP_AZ: begin
                  az_in    = q16;
                  op_in    = zbr_pkg::OP_BX;
                  state_in = zbr_pkg::S_MUL;
               end
               zbr_pkg::OP_BX: begin
                  bx_in    = q16[11:0];
                  op_in    = zbr_pkg::OP_BZ;
                  state_in = zbr_pkg::S_MUL;
               end
               zbr_pkg::OP_BZ: begin
                  bz_in    = q16;
                  state_in = zbr_pkg::S_SWAP;
               end
               default: begin
                  px_in    = x_ff;
                  py_in    = row;
                  pz_in    = q16;
                  ret_in   = zbr_pkg::S_SPNX;
                  state_in = zbr_pkg::S_PLOT;
               end
            endcase
         end
         zbr_pkg::S_SWAP: begin
            // order the edge points left to right, then plot the left one
            if (ax_ff > bx_ff) begin
               ax_in = bx_ff;
               bx_in = ax_ff;
               az_in = bz_ff;
               bz_in = az_ff;
               px_in = 13'(bx_ff);
               pz_in = bz_ff;
            end else begin
               px_in = 13'(ax_ff);
               pz_in = az_ff;
            end
            py_in    = row;
            ret_in   = zbr_pkg::S_PLOTB;
            state_in = zbr_pkg::S_PLOT;
         end
         zbr_pkg::S_PLOTB: begin
            px_in    = 13'(bx_ff);
            pz_in    = bz_ff;
            py_in    = row;
            x_in     = 13'(ax_ff) + 13'sd1;
            ret_in   = zbr_pkg::S_SPAN;
            state_in = zbr_pkg::S_PLOT;
         end
         zbr_pkg::S_SPAN: begin
            if (x_ff < 13'(bx_ff)) begin
               op_in    = zbr_pkg::OP_SZ;
               state_in = zbr_pkg::S_MUL;
            end else begin
               dy_in    = dy_ff + 1'b1;
               state_in = zbr_pkg::S_ROW;
            end
         end
         zbr_pkg::S_SPNX: begin
            x_in     = x_ff + 13'sd1;
            state_in = zbr_pkg::S_SPAN;
         end
         zbr_pkg::S_PLOT: begin
            // read the stored depth; drop the plot outside the viewport
            paddr_in = plot_lin[AW-1:0];
            state_in = plot_in_range ? zbr_pkg::S_PCMP : ret_ff;
         end
         zbr_pkg::S_PCMP: begin
            mem_we   = rd_depth_ff < pz_ff;
            state_in = ret_ff;
         end
         zbr_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cmd_ff;
               rsp_color_in = (cmd_ff == zbr_pkg::CMD_READ) ? res_color_ff : 24'd0;
               rsp_depth_in = (cmd_ff == zbr_pkg::CMD_READ) ? res_depth_ff : 16'sd0;
               state_in     = zbr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = zbr_pkg::S_IDLE;
         end
      endcase
   end

   // ----------------------------------------------------------- config port
   always_comb begin
      csr_write = psel && penable && pwrite;
      vw_in     = vw_ff;
      vh_in     = vh_ff;
      if (csr_write) begin
         unique case (paddr[2])
            zbr_pkg::REG_VIEWPORT_WIDTH:  vw_in = pwdata[8:0];
            zbr_pkg::REG_VIEWPORT_HEIGHT: vh_in = pwdata[8:0];
            default:                      vw_in = vw_ff;
         endcase
      end
      unique case (paddr[2])
         zbr_pkg::REG_VIEWPORT_WIDTH:  prdata = {23'd0, vw_ff};
         zbr_pkg::REG_VIEWPORT_HEIGHT: prdata = {23'd0, vh_ff};
         default:                      prdata = 32'd0;
      endcase
      pready = 1'b1;
   end

   // ------------------------------------------------------- register update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zbr_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         vw_ff        <= zbr_pkg::VIEWPORT_RESET;
         vh_ff        <= zbr_pkg::VIEWPORT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         vw_ff        <= vw_in;
         vh_ff        <= vh_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff       <= ret_in;
      op_ff        <= op_in;
      v0_ff        <= v0_in;
      v1_ff        <= v1_in;
      v2_ff        <= v2_in;
      cmd_ff       <= cmd_in;
      color_ff     <= color_in;
      ridx_ff      <= ridx_in;
      dy_ff        <= dy_in;
      ax_ff        <= ax_in;
      bx_ff        <= bx_in;
      az_ff        <= az_in;
      bz_ff        <= bz_in;
      x_ff         <= x_in;
      prod1_ff     <= prod1_in;
      prod2_ff     <= prod2_in;
      den_ff       <= den_in;
      neg_ff       <= neg_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      paddr_ff     <= paddr_in;
      res_color_ff <= res_color_in;
      res_depth_ff <= res_depth_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_color_ff <= rsp_color_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_response_kind = rsp_kind_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_pixel_depth   = rsp_depth_ff;

   // -------------------------------------------------------------- checks
   logic we_state_ok;
   logic rsp_draw;
   logic rsp_zero;

   assign we_state_ok = (state_ff == zbr_pkg::S_CLEAR) || (state_ff == zbr_pkg::S_PCMP);
   assign rsp_draw    = rsp_valid_ff && (rsp_kind_ff == zbr_pkg::CMD_DRAW);
   assign rsp_zero    = (rsp_color_ff == 24'd0) && (rsp_depth_ff == 16'sd0);

   `ZBR_ASSERT_IMPLY(a_we_state, clock, reset, mem_we, we_state_ok)
   `ZBR_ASSERT_IMPLY(a_draw_zero, clock, reset, rsp_draw, rsp_zero)
   `ZBR_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, state_ff != zbr_pkg::S_IDLE)
   `ZBR_ASSERT_IMPLY(a_div_nonzero, clock, reset, state_ff == zbr_pkg::S_DIV, den_ff != 13'd0)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the z-buffer triangle rasterizer.
// Depends on zbr_pkg and zbuffer_triangle_rasterizer; it predicts every response
// from a local copy of the depth and color stores and of the viewport registers.
`timescale 1ns / 1ps

module testbench;

   localparam int  STORE_H     = zbr_pkg::MAX_HEIGHT_DEF;
   localparam int  STORE_N     = zbr_pkg::MAX_WIDTH_DEF * zbr_pkg::MAX_HEIGHT_DEF;
   localparam int  IDLE_LIMIT  = 200000;

   typedef struct {
      logic               command;
      logic signed [11:0] x0, y0, x1, y1, x2, y2;
      logic signed [15:0] z0, z1, z2;
      logic        [23:0] fill_color;
      logic        [15:0] read_index;
   } cmd_type;

   typedef struct {
      logic               kind;
      logic        [23:0] color;
      logic signed [15:0] depth;
   } pixel_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = zbr_pkg::CMD_DRAW;
   logic signed [11:0] req_x0 = '0, req_y0 = '0, req_x1 = '0, req_y1 = '0;
   logic signed [11:0] req_x2 = '0, req_y2 = '0;
   logic signed [15:0] req_z0 = '0, req_z1 = '0, req_z2 = '0;
   logic        [23:0] req_fill_color = '0;
   logic        [15:0] req_read_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_response_kind;
   logic        [23:0] rsp_pixel_color;
   logic signed [15:0] rsp_pixel_depth;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // local copy of the pixel stores and viewport
   logic signed [15:0] depth_copy [STORE_N];
   logic        [23:0] color_copy [STORE_N];
   logic [8:0]  vp_width = zbr_pkg::VIEWPORT_RESET;
   logic [8:0]  vp_height = zbr_pkg::VIEWPORT_RESET;

   pixel_rsp_type pending_pixels[$];
   int  n_fail = 0;
   int  n_draws = 0, n_reads = 0, n_checked = 0, n_written = 0;
   int  idle_cycles = 0;
   int  hold_cycles = 0;
   bit  quiet = 1'b0;
   int  last_x = 0, last_y = 0;

   zbuffer_triangle_rasterizer i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_x0(req_x0), .req_y0(req_y0), .req_z0(req_z0),
      .req_x1(req_x1), .req_y1(req_y1), .req_z1(req_z1),
      .req_x2(req_x2), .req_y2(req_y2), .req_z2(req_z2),
      .req_fill_color(req_fill_color), .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_response_kind(rsp_response_kind), .rsp_pixel_color(rsp_pixel_color),
      .rsp_pixel_depth(rsp_pixel_depth),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < STORE_N; i++) begin
         depth_copy[i] = zbr_pkg::DEPTH_RESET;
         color_copy[i] = '0;
      end
   end

   // ---------------- predictor ----------------
   function automatic longint lerp(longint base, longint delta, longint num, longint den);
      return (base * den + delta * num) / den;
   endfunction

   function automatic void plot_pixel(longint x, longint y, longint z, logic [23:0] color);
      longint w, h, idx;
      w = (vp_width  < zbr_pkg::MAX_WIDTH_DEF)  ? longint'(vp_width)
                                                : longint'(zbr_pkg::MAX_WIDTH_DEF);
      h = (vp_height < zbr_pkg::MAX_HEIGHT_DEF) ? longint'(vp_height)
                                                : longint'(zbr_pkg::MAX_HEIGHT_DEF);
      if (x < 0 || x >= w || y < 0 || y >= h) return;
      idx = x * STORE_H + y;
      if (longint'(depth_copy[idx]) < z) begin
         depth_copy[idx] = 16'(z);
         color_copy[idx] = color;
         n_written++;
      end
   endfunction

   function automatic void raster_triangle(cmd_type c);
      longint vx[3], vy[3], vz[3];
      longint t, total, first, span, row, ax, az, bx, bz;
      bit upper;
      vx[0] = longint'(c.x0); vy[0] = longint'(c.y0); vz[0] = longint'(c.z0);
      vx[1] = longint'(c.x1); vy[1] = longint'(c.y1); vz[1] = longint'(c.z1);
      vx[2] = longint'(c.x2); vy[2] = longint'(c.y2); vz[2] = longint'(c.z2);
      if (vy[0] == vy[1] && vy[0] == vy[2]) return;
      if (vx[0] == vx[1] && vx[0] == vx[2]) return;
      for (int p = 0; p < 3; p++) begin
         // conditional swaps (0,1), (0,2), (1,2)
         int i, j;
         i = (p == 2) ? 1 : 0;
         j = (p == 0) ? 1 : 2;
         if (vy[i] > vy[j]) begin
            t = vx[i]; vx[i] = vx[j]; vx[j] = t;
            t = vy[i]; vy[i] = vy[j]; vy[j] = t;
            t = vz[i]; vz[i] = vz[j]; vz[j] = t;
         end
      end
      plot_pixel(vx[2], vy[2], vz[2], c.fill_color);
      total = vy[2] - vy[0];
      first = vy[1] - vy[0];
      span  = vy[2] - vy[1];
      for (longint dy = 0; dy < total; dy++) begin
         upper = (dy > first) || (first == 0);
         row = vy[0] + dy;
         ax = lerp(vx[0], vx[2] - vx[0], dy, total);
         az = lerp(vz[0], vz[2] - vz[0], dy, total);
         if (!upper) begin
            bx = lerp(vx[0], vx[1] - vx[0], dy, first);
            bz = lerp(vz[0], vz[1] - vz[0], dy, first);
         end else begin
            bx = lerp(vx[1], vx[2] - vx[1], dy - first, span);
            bz = lerp(vz[1], vz[2] - vz[1], dy - first, span);
         end
         if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = az; az = bz; bz = t;
         end
         plot_pixel(ax, row, az, c.fill_color);
         plot_pixel(bx, row, bz, c.fill_color);
         for (longint x = ax + 1; x < bx; x++)
            plot_pixel(x, row, lerp(az, bz - az, x - ax, bx - ax), c.fill_color);
      end
   endfunction

   function automatic pixel_rsp_type predict_pixels(cmd_type c);
      pixel_rsp_type r;
      r.kind = c.command;
      r.color = '0;
      r.depth = '0;
      if (c.command == zbr_pkg::CMD_DRAW) begin
         raster_triangle(c);
      end else if (int'(c.read_index) < STORE_N) begin
         r.color = color_copy[c.read_index];
         r.depth = depth_copy[c.read_index];
      end
      return r;
   endfunction

   // ---------------- drivers ----------------
   task automatic send_cmd(cmd_type c);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= c.command;
      req_x0 <= c.x0; req_y0 <= c.y0; req_z0 <= c.z0;
      req_x1 <= c.x1; req_y1 <= c.y1; req_z1 <= c.z1;
      req_x2 <= c.x2; req_y2 <= c.y2; req_z2 <= c.z2;
      req_fill_color <= c.fill_color;
      req_read_index <= c.read_index;
      // ready only moves at rising edges, so the falling edge sees the value that counts
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      pending_pixels.push_back(predict_pixels(c));
      if (c.command == zbr_pkg::CMD_DRAW) n_draws++; else n_reads++;
      // hold valid; the next item or an explicit drop lowers it at this edge
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_viewport(logic addr_sel, logic [8:0] value);
      wait_drained();
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= (addr_sel == zbr_pkg::REG_VIEWPORT_HEIGHT) ? 3'd4 : 3'd0;
      pwdata <= {23'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr_sel == zbr_pkg::REG_VIEWPORT_HEIGHT) vp_height = value; else vp_width = value;
   endtask

   function automatic cmd_type make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, logic [23:0] color);
      cmd_type c;
      c.command = zbr_pkg::CMD_DRAW;
      c.x0 = 12'(ax); c.y0 = 12'(ay); c.z0 = 16'(az);
      c.x1 = 12'(bx); c.y1 = 12'(by); c.z1 = 16'(bz);
      c.x2 = 12'(cx); c.y2 = 12'(cy); c.z2 = 16'(cz);
      c.fill_color = color;
      c.read_index = 16'($urandom);
      return c;
   endfunction

   function automatic cmd_type make_read(int x, int y);
      cmd_type c;
      c = make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'($urandom));
      c.command = zbr_pkg::CMD_READ;
      c.read_index = 16'(((x & 255) << 8) | (y & 255));
      return c;
   endfunction

   task automatic read_around(int x, int y, int n);
      for (int i = 0; i < n; i++)
         send_cmd(make_read(x + $urandom_range(0, 8), y + $urandom_range(0, 8)));
   endtask

   function automatic cmd_type random_tri();
      int bx, by;
      if ($urandom_range(0, 7) == 0) begin
         bx = $urandom_range(0, 4083) - 2048;
         by = $urandom_range(0, 4083) - 2048;
      end else begin
         bx = $urandom_range(0, 250) - 4;
         by = $urandom_range(0, 250) - 4;
      end
      last_x = bx; last_y = by;
      return make_tri(bx + $urandom_range(0, 12), by + $urandom_range(0, 12),
                      int'(16'sh0 + $signed(16'($urandom))),
                      bx + $urandom_range(0, 12), by + $urandom_range(0, 12),
                      int'($signed(16'($urandom))),
                      bx + $urandom_range(0, 12), by + $urandom_range(0, 12),
                      int'($signed(16'($urandom))), 24'($urandom));
   endfunction

   // ---------------- response checker ----------------
   always @(negedge clock) begin
      pixel_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: response with none expected (kind %0d)", $time, rsp_response_kind);
            n_fail++;
         end else begin
            want = pending_pixels.pop_front();
            n_checked++;
            if (rsp_response_kind !== want.kind) begin
               $display("%0t: response_kind expected %0d actual %0d", $time, want.kind,
                        rsp_response_kind);
               n_fail++;
            end
            if (rsp_pixel_color !== want.color) begin
               $display("%0t: pixel_color expected %h actual %h", $time, want.color,
                        rsp_pixel_color);
               n_fail++;
            end
            if (rsp_pixel_depth !== want.depth) begin
               $display("%0t: pixel_depth expected %0d actual %0d", $time, want.depth,
                        rsp_pixel_depth);
               n_fail++;
            end
         end
      end
   end

   // receiver back-pressure: short random bursts, plus a long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 11);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer; the reset clearing pass counts too
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_reset_state();
      send_cmd(make_read(0, 0));
      send_cmd(make_read(255, 255));
   endtask

   task automatic test_degenerate();
      // one shared row, then two shared columns, at the coordinate extremes
      send_cmd(make_tri(-2048, 2047, 32767, 2047, 2047, -32768, 0, 2047, 5, 24'hFFFFFF));
      send_cmd(make_tri(-2048, -2048, 100, -2048, 2047, 200, -2048, 0, 300, 24'h123456));
      send_cmd(make_tri(2047, -2048, 100, 2047, 2047, 200, 2047, 5, 300, 24'h654321));
      send_cmd(make_read(0, 0));
   endtask

   task automatic test_fill_and_depth();
      send_cmd(make_tri(2, 3, 1000, 10, 5, -1000, 5, 12, 32767, 24'hA5A5A5));
      read_around(2, 3, 4);
      // same triangle at the same depth must not overwrite
      send_cmd(make_tri(2, 3, 1000, 10, 5, -1000, 5, 12, 32767, 24'h5A5A5A));
      // most negative depth never wins against the cleared store
      send_cmd(make_tri(30, 30, -32768, 38, 31, -32768, 33, 40, -32768, 24'h00FF00));
      read_around(30, 30, 3);
      // flat-top and flat-bottom halves
      send_cmd(make_tri(50, 50, 10, 58, 50, 20, 54, 58, 30, 24'h0000FF));
      send_cmd(make_tri(60, 60, 10, 64, 68, 20, 56, 68, 30, 24'hFF0000));
      read_around(50, 50, 2);
      read_around(56, 60, 2);
   endtask

   task automatic test_viewport();
      write_viewport(zbr_pkg::REG_VIEWPORT_WIDTH, 9'd4);
      write_viewport(zbr_pkg::REG_VIEWPORT_HEIGHT, 9'd1);
      send_cmd(make_tri(0, 0, 500, 8, 0, 500, 3, 6, 500, 24'h111111));
      read_around(0, 0, 2);
      write_viewport(zbr_pkg::REG_VIEWPORT_WIDTH, 9'd0);
      send_cmd(make_tri(0, 0, 600, 8, 2, 600, 3, 6, 600, 24'h222222));
      write_viewport(zbr_pkg::REG_VIEWPORT_WIDTH, 9'd511);
      write_viewport(zbr_pkg::REG_VIEWPORT_HEIGHT, 9'd300);
      // crosses the right and bottom edges of the store
      send_cmd(make_tri(250, 250, 700, 300, 252, 700, 252, 300, 700, 24'h333333));
      read_around(247, 247, 2);
   endtask

   task automatic test_pressure();
      wait_drained();
      hold_cycles = 2500;
      for (int i = 0; i < 10; i++)
         send_cmd(make_read($urandom_range(0, 255), $urandom_range(0, 255)));
   endtask

   task automatic test_random(int n_items);
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 3) begin
            write_viewport(zbr_pkg::REG_VIEWPORT_WIDTH, 9'($urandom_range(1, 256)));
            write_viewport(zbr_pkg::REG_VIEWPORT_HEIGHT, 9'($urandom_range(1, 256)));
         end else if (i == 2 * n_items / 3) begin
            write_viewport(zbr_pkg::REG_VIEWPORT_WIDTH, zbr_pkg::VIEWPORT_RESET);
            write_viewport(zbr_pkg::REG_VIEWPORT_HEIGHT, zbr_pkg::VIEWPORT_RESET);
         end
         if (i == n_items - 40) quiet = 1'b1;
         if ($urandom_range(0, 99) < 45) begin
            send_cmd(random_tri());
         end else if ($urandom_range(0, 3) == 0) begin
            cmd_type c;
            c = make_read(0, 0);
            c.read_index = 16'($urandom);
            send_cmd(c);
         end else begin
            send_cmd(make_read(last_x + $urandom_range(0, 12), last_y + $urandom_range(0, 12)));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_degenerate();
      test_fill_and_depth();
      test_viewport();
      test_pressure();
      test_random(255);
      req_valid <= 1'b0;
      fork
         wait (pending_pixels.size() == 0);
         repeat (IDLE_LIMIT) @(posedge clock);
      join_any
      repeat (50) @(posedge clock);
      $display("Covered %0d draws and %0d reads, %0d responses checked, %0d pixel writes",
               n_draws, n_reads, n_checked, n_written);
      $display("Viewport swept through zero, one, mid, reset and above-maximum settings");
      if (pending_pixels.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_pixels.size());
         n_fail++;
      end
      if (n_fail == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/zbr_pkg.sv
rtl/core/zbuffer_triangle_rasterizer.sv
tb/sv/testbench.sv
